// File: hdl/abmd_pkg.sv
package abmd_pkg;

  // operation codes of a command word
  localparam logic [2:0] FUNC_READ   = 3'd0;
  localparam logic [2:0] FUNC_WRITE  = 3'd1;
  localparam logic [2:0] FUNC_LOAD   = 3'd2;
  localparam logic [2:0] FUNC_DIRTY  = 3'd3;
  localparam logic [2:0] FUNC_VBLANK = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_C = 2'd2;

  // memory map
  localparam logic [15:0] ZERO_PAGE_END  = 16'h00ff;
  localparam logic [15:0] RAM_LO         = 16'h2800;
  localparam logic [15:0] RAM_HI         = 16'h37ff;
  localparam logic [15:0] VRAM_LO        = 16'h3800;
  localparam logic [15:0] VRAM_HI        = 16'h3fff;
  localparam logic [15:0] ADDR_SOUND_IRQ = 16'h2002;
  localparam logic [15:0] ADDR_FLIP      = 16'h2006;
  localparam logic [15:0] ADDR_IRQ_EN    = 16'h2007;
  localparam logic [15:0] ADDR_PALETTE   = 16'h2200;
  localparam logic [15:0] ADDR_SYSTEM    = 16'h2400;
  localparam logic [15:0] ADDR_P1        = 16'h2401;
  localparam logic [15:0] ADDR_P2        = 16'h2402;
  localparam logic [15:0] ADDR_DIP_C     = 16'h2403;
  localparam logic [15:0] ADDR_DIP_A     = 16'h2500;
  localparam logic [15:0] ADDR_DIP_B     = 16'h2501;
  localparam logic [15:0] SOUND_LATCH    = 16'h2400;

  localparam logic [7:0] OPEN_BUS = 8'hff;

endpackage

// File: hdl/abmd_if.sv
interface abmd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [15:0] address;
  logic [7:0] data_in;
  logic [7:0] player_one_port;
  logic [7:0] player_two_port;
  logic [7:0] system_port;

  modport source (output valid, func, address, data_in, player_one_port, player_two_port,
                  system_port, input ready);
  modport sink (input valid, func, address, data_in, player_one_port, player_two_port,
                system_port, output ready);
endinterface

interface abmd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       dirty_flag;
  logic       sound_irq_pulse;
  logic       main_irq_assert;
  logic       main_irq_clear;
  logic       flip_level;
  logic [2:0] palette_level;
  logic [7:0] latch_level;

  modport source (output valid, read_data, dirty_flag, sound_irq_pulse, main_irq_assert,
                  main_irq_clear, flip_level, palette_level, latch_level, input ready);
  modport sink (input valid, read_data, dirty_flag, sound_irq_pulse, main_irq_assert,
                main_irq_clear, flip_level, palette_level, latch_level, output ready);
endinterface

interface abmd_cfg_if;
  logic       valid;
  logic       ready;
  logic [abmd_pkg::CFG_IDX_W-1:0] index;
  logic [7:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// File: hdl/arcade_main_bus_decoder_core.sv
// result: a result word is registered into the output register when execute commits
// flow: a new command word is taken only once the last one has committed, as the work
//   memory read is issued at accept and its write-back at commit
// reset: synchronous, active high; clears latches, DIP registers and the output
//   valid flag, then a pass over all TILE_COUNT tiles sets every dirty mark; a palette bank
//   change runs the same pass; commands wait during the pass, config is always taken
module arcade_main_bus_decoder_core #(
  parameter int unsigned TILE_COUNT = 1024
) (
  input logic clk,
  input logic rst,
  abmd_cfg_if.sink   cfg,
  abmd_cmd_if.sink   cmd,
  abmd_rsp_if.source rsp
);

  localparam int unsigned TW = $clog2(TILE_COUNT);

  // sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // tile of an address: low ten bits modulo tile count, by up to four compare-subtracts (exact for TILE_COUNT >= 205)
  function automatic logic [TW-1:0] tile_of(input logic [9:0] a);
    logic [12:0] v;
    v = {3'b000, a};
    for (int i = 0; i < 4; i++) begin
      if (v >= 13'(TILE_COUNT)) begin
        v = v - 13'(TILE_COUNT);
      end
    end
    return v[TW-1:0];
  endfunction

  // storage
  logic [7:0] work_mem  [65536];
  logic       dirty_mem [TILE_COUNT];

  logic [1:0]    state;
  logic [TW-1:0] clr_idx;

  // config registers
  logic [7:0] dip_a;
  logic [7:0] dip_b;
  logic [7:0] dip_c;

  // latches
  logic [2:0] palette_bank, palette_bank_next;
  logic [7:0] sound_latch, sound_latch_next;
  logic [7:0] last_trig, last_trig_next;
  logic       irq_en, irq_en_next;
  logic       flip, flip_next;

  // captured command word
  logic [2:0]    func_q;
  logic [15:0]   addr_q;
  logic [7:0]    data_q;
  logic [7:0]    p1_q;
  logic [7:0]    p2_q;
  logic [7:0]    sys_q;
  logic [TW-1:0] tile_q;

  // memory read data
  logic [7:0] mem_rd;
  logic       dirty_rd;

  logic cmd_acc;
  logic commit;

  // execute-stage results
  logic       mem_we;
  logic       dirty_we;
  logic       dirty_wval;
  logic       pal_change;
  logic [7:0] rd_byte;
  logic       snd_pulse;
  logic       irq_assert;
  logic       irq_clear;
  logic       dflag;

  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_acc   = cmd.valid && cmd.ready;
  // result leaves execute once the output register is free or being drained
  assign commit    = (state == ST_EXEC) && (!rsp.valid || rsp.ready);

  // config writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      dip_a <= '0;
      dip_b <= '0;
      dip_c <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        abmd_pkg::CFG_DIP_A: dip_a <= cfg.wdata;
        abmd_pkg::CFG_DIP_B: dip_b <= cfg.wdata;
        abmd_pkg::CFG_DIP_C: dip_c <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // capture the command word and issue both memory reads
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      func_q <= cmd.func;
      addr_q <= cmd.address;
      data_q <= cmd.data_in;
      p1_q   <= cmd.player_one_port;
      p2_q   <= cmd.player_two_port;
      sys_q  <= cmd.system_port;
      tile_q <= tile_of(cmd.address[9:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      mem_rd <= work_mem[cmd.address];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      work_mem[addr_q] <= data_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      dirty_rd <= dirty_mem[tile_of(cmd.address[9:0])];
    end
  end

  // single write port: clearing pass sets marks, execute sets or takes one
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      dirty_mem[clr_idx] <= 1'b1;
    end else if (dirty_we) begin
      dirty_mem[tile_q] <= dirty_wval;
    end
  end

  // execute: decode, modify and choose what goes back
  always_comb begin
    logic work_rd;
    logic plain_st;
    logic vram;
    logic is_wr;

    work_rd  = (addr_q <= abmd_pkg::ZERO_PAGE_END) || (addr_q >= abmd_pkg::RAM_LO);
    plain_st = (addr_q <= abmd_pkg::ZERO_PAGE_END)
            || ((addr_q >= abmd_pkg::RAM_LO) && (addr_q <= abmd_pkg::RAM_HI));
    vram     = (addr_q >= abmd_pkg::VRAM_LO) && (addr_q <= abmd_pkg::VRAM_HI);
    is_wr    = (func_q == abmd_pkg::FUNC_WRITE);

    palette_bank_next = palette_bank;
    sound_latch_next  = sound_latch;
    last_trig_next    = last_trig;
    irq_en_next       = irq_en;
    flip_next         = flip;
    mem_we            = 1'b0;
    dirty_we          = 1'b0;
    dirty_wval        = 1'b0;
    pal_change        = 1'b0;
    rd_byte           = '0;
    snd_pulse         = 1'b0;
    irq_assert        = 1'b0;
    irq_clear         = 1'b0;
    dflag             = 1'b0;

    case (func_q)
      abmd_pkg::FUNC_READ: begin
        case (addr_q)
          abmd_pkg::ADDR_SYSTEM: rd_byte = sys_q;
          abmd_pkg::ADDR_P1:     rd_byte = p1_q;
          abmd_pkg::ADDR_P2:     rd_byte = p2_q;
          abmd_pkg::ADDR_DIP_C:  rd_byte = dip_c;
          abmd_pkg::ADDR_DIP_A:  rd_byte = dip_a;
          abmd_pkg::ADDR_DIP_B:  rd_byte = dip_b;
          default:               rd_byte = work_rd ? mem_rd : abmd_pkg::OPEN_BUS;
        endcase
      end
      abmd_pkg::FUNC_WRITE: begin
        // video ram only stores and marks its tile when the byte changes
        if (plain_st) begin
          mem_we = 1'b1;
        end else if (vram && (mem_rd != data_q)) begin
          mem_we     = 1'b1;
          dirty_we   = 1'b1;
          dirty_wval = 1'b1;
        end
      end
      abmd_pkg::FUNC_LOAD: begin
        mem_we = 1'b1;
      end
      abmd_pkg::FUNC_DIRTY: begin
        dflag      = dirty_rd;
        dirty_we   = 1'b1;
        dirty_wval = 1'b0;
      end
      abmd_pkg::FUNC_VBLANK: begin
        irq_assert = irq_en;
      end
      default: ;
    endcase

    if (is_wr) begin
      case (addr_q)
        abmd_pkg::ADDR_SOUND_IRQ: begin
          // rising trigger: previous value zero, new value exactly one
          snd_pulse      = (last_trig == 8'd0) && (data_q == 8'd1);
          last_trig_next = data_q;
        end
        abmd_pkg::ADDR_FLIP: flip_next = data_q[0];
        abmd_pkg::ADDR_IRQ_EN: begin
          irq_en_next = (data_q != 8'd0);
          irq_clear   = (data_q == 8'd0);
        end
        abmd_pkg::ADDR_PALETTE: begin
          palette_bank_next = data_q[2:0];
          pal_change        = (data_q[2:0] != palette_bank);
        end
        abmd_pkg::SOUND_LATCH: sound_latch_next = data_q;
        default: ;
      endcase
    end

    // nothing commits until the output register is free
    if (!commit) begin
      mem_we   = 1'b0;
      dirty_we = 1'b0;
    end
  end

  // sequencer, clearing pass and latches
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      palette_bank <= '0;
      sound_latch  <= '0;
      last_trig    <= '0;
      irq_en       <= 1'b0;
      flip         <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_idx == TW'(TILE_COUNT - 1)) begin
            clr_idx <= '0;
            state   <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_acc) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            palette_bank <= palette_bank_next;
            sound_latch  <= sound_latch_next;
            last_trig    <= last_trig_next;
            irq_en       <= irq_en_next;
            flip         <= flip_next;
            state        <= pal_change ? ST_CLEAR : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.read_data       <= rd_byte;
      rsp.dirty_flag      <= dflag;
      rsp.sound_irq_pulse <= snd_pulse;
      rsp.main_irq_assert <= irq_assert;
      rsp.main_irq_clear  <= irq_clear;
      rsp.flip_level      <= flip_next;
      rsp.palette_level   <= palette_bank_next;
      rsp.latch_level     <= sound_latch_next;
    end
  end

endmodule

// File: hdl/abmd_checker.sv
module abmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] read_data,
  input logic       dirty_flag,
  input logic       sound_irq_pulse,
  input logic       main_irq_assert,
  input logic       main_irq_clear
);

  // command words taken but not yet answered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(cmd_valid && cmd_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word shown right after reset");

  a_held_when_stalled: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(dirty_flag))
    else $error("stalled result word changed");

  a_no_unasked_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result word without a command word");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($countones({dirty_flag, sound_irq_pulse, main_irq_assert,
                               main_irq_clear}) <= 1)
                  && ((read_data == 8'd0) || !(dirty_flag || sound_irq_pulse
                      || main_irq_assert || main_irq_clear)))
    else $error("result word mixes events of different operations");

endmodule

bind arcade_main_bus_decoder_core abmd_checker u_abmd_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .read_data       (rsp.read_data),
  .dirty_flag      (rsp.dirty_flag),
  .sound_irq_pulse (rsp.sound_irq_pulse),
  .main_irq_assert (rsp.main_irq_assert),
  .main_irq_clear  (rsp.main_irq_clear)
);
